// ===== hw/rtl/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants of the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

    localparam int COORD_BITS = 16;
    localparam int IN_W       = 16;
    localparam int SUM_W      = ((COORD_BITS > IN_W) ? COORD_BITS : IN_W) + 2;
    localparam int DEC_W      = IN_W + 4;
    localparam int SIZE_W     = 11;
    localparam int PIX_W      = 10;
    localparam int IDX_W      = 3;
    localparam int MAX_DISP   = 1024;
    localparam int JQ_DEPTH   = 4;
    localparam int JQ_AW      = $clog2(JQ_DEPTH);

    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    localparam logic [1:0] K_START_OUT = 2'd0;
    localparam logic [1:0] K_SPAN1     = 2'd1;
    localparam logic [1:0] K_ADV_FILL  = 2'd2;
    localparam logic [1:0] K_ADV_OUT   = 2'd3;

    typedef struct packed {
        logic                   func;
        logic signed [IN_W-1:0] center_x;
        logic signed [IN_W-1:0] center_y;
        logic signed [IN_W-1:0] radius;
        logic                   fill;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0] span_start;
        logic [PIX_W-1:0] span_end;
        logic [PIX_W-1:0] row;
        logic             visible;
        logic             last;
        logic             done_res;
    } t_out;

    typedef struct packed {
        logic [1:0]                   kind;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic [IN_W-1:0]              x;
        logic [IN_W-1:0]              y;
        logic                         done;
    } t_job;

    function automatic logic signed [COORD_BITS-1:0] load_coord(
        input logic signed [IN_W-1:0] v
    );
        logic signed [47:0] t;
        t = 48'(v);
        return t[COORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mcr_front.sv =====
// ----------------------------------------------------------------------------
// mcr_front
// Decodes start/advance items, steps the midpoint decision terms and
// issues one emit job per item that produces results.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire mcr_pkg::t_in  i_item,
    output logic               o_job_valid,
    output mcr_pkg::t_job      o_job
);
    import mcr_pkg::*;

    logic signed [COORD_BITS-1:0] r_cx, n_cx;
    logic signed [COORD_BITS-1:0] r_cy, n_cy;
    logic [IN_W-1:0]              r_sc, n_sc;
    logic [IN_W-1:0]              r_sr, n_sr;
    logic signed [DEC_W-1:0]      r_dec, n_dec;
    logic signed [DEC_W-1:0]      r_dcol, n_dcol;
    logic signed [DEC_W-1:0]      r_drow, n_drow;
    logic                         r_fill, n_fill;
    logic                         r_active, n_active;

    logic signed [DEC_W-1:0] w_rad;
    logic signed [DEC_W-1:0] w_dec_t;

    always_comb begin
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_sc        = r_sc;
        n_sr        = r_sr;
        n_dec       = r_dec;
        n_dcol      = r_dcol;
        n_drow      = r_drow;
        n_fill      = r_fill;
        n_active    = r_active;
        o_job_valid = 1'b0;
        o_job       = '0;
        w_rad       = DEC_W'(i_item.radius);
        w_dec_t     = r_dec;
        if (i_accept) begin
            if (i_item.func == FUNC_START) begin
                n_cx     = load_coord(i_item.center_x);
                n_cy     = load_coord(i_item.center_y);
                n_fill   = i_item.fill;
                n_active = 1'b0;
                o_job.cx = load_coord(i_item.center_x);
                o_job.cy = load_coord(i_item.center_y);
                if (i_item.radius == '0) begin
                    o_job_valid = 1'b1;
                    o_job.kind  = K_SPAN1;
                    o_job.done  = 1'b1;
                end else if (!i_item.radius[IN_W-1]) begin
                    n_dec       = DEC_W'(1) - w_rad;
                    n_dcol      = DEC_W'(1);
                    n_drow      = -(w_rad <<< 1);
                    n_sc        = '0;
                    n_sr        = i_item.radius;
                    n_active    = 1'b1;
                    o_job_valid = 1'b1;
                    o_job.kind  = i_item.fill ? K_SPAN1 : K_START_OUT;
                    o_job.y     = i_item.radius;
                end
            end else if (r_active) begin
                if (r_dec >= 0) begin
                    n_sr    = r_sr - 1'b1;
                    n_drow  = r_drow + DEC_W'(2);
                    w_dec_t = r_dec + n_drow;
                end
                n_sc        = r_sc + 1'b1;
                n_dcol      = r_dcol + DEC_W'(2);
                n_dec       = w_dec_t + n_dcol;
                n_active    = n_sc < n_sr;
                o_job_valid = 1'b1;
                o_job.kind  = r_fill ? K_ADV_FILL : K_ADV_OUT;
                o_job.cx    = r_cx;
                o_job.cy    = r_cy;
                o_job.x     = n_sc;
                o_job.y     = n_sr;
                o_job.done  = !(n_sc < n_sr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_sc     <= '0;
            r_sr     <= '0;
            r_dec    <= '0;
            r_dcol   <= '0;
            r_drow   <= '0;
            r_fill   <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_sc     <= n_sc;
            r_sr     <= n_sr;
            r_dec    <= n_dec;
            r_dcol   <= n_dcol;
            r_drow   <= n_drow;
            r_fill   <= n_fill;
            r_active <= n_active;
        end
    end

`ifndef SYNTHESIS
    a_active_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_sc < r_sr)
        else $error("active circle with step_col >= step_row");
    a_adv_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.func == FUNC_ADVANCE && !r_active) |-> !o_job_valid)
        else $error("job issued for advance while idle");
    a_neg_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.func == FUNC_START && i_item.radius[IN_W-1]) |=> !r_active)
        else $error("negative radius left a circle active");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mcr_job_queue.sv =====
// ----------------------------------------------------------------------------
// mcr_job_queue
// Small FIFO of emit jobs between the decode front and the emit back.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_job_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mcr_pkg::t_job  i_job,
    output logic                o_full,
    output logic                o_valid,
    output mcr_pkg::t_job       o_job,
    input  wire logic           i_pop
);
    import mcr_pkg::*;

    t_job             r_mem [JQ_DEPTH];
    logic [JQ_AW-1:0] r_wr, r_rd;
    logic [JQ_AW:0]   r_cnt;
    logic             w_push, w_pop;

    assign o_full  = r_cnt == (JQ_AW+1)'(JQ_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (JQ_AW+1)'(w_push) - (JQ_AW+1)'(w_pop);
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (JQ_AW+1)'(JQ_DEPTH))
        else $error("job queue count out of range");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != (JQ_AW+1)'(JQ_DEPTH)) |-> (JQ_AW'(r_wr - r_rd) == r_cnt[JQ_AW-1:0]))
        else $error("job queue pointers disagree with count");
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full && !i_pop) |=> $stable(r_cnt))
        else $error("job queue count moved on a blocked push");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mcr_back.sv =====
// ----------------------------------------------------------------------------
// mcr_back
// Expands each job into its mirrored pixels or spans, one per cycle while
// the result buffer has room, clips them to the display and buffers them for the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_job_valid,
    input  wire mcr_pkg::t_job                   i_job,
    output logic                                 o_job_pop,
    input  wire logic [mcr_pkg::SIZE_W-1:0]      i_width,
    input  wire logic [mcr_pkg::SIZE_W-1:0]      i_height,
    output logic                                 o_empty,
    input  wire logic                            i_pop,
    output mcr_pkg::t_out                        o_result
);
    import mcr_pkg::*;

    localparam int OB_DEPTH = 2;

    t_out             r_ob [OB_DEPTH];
    logic             r_ob_wr, r_ob_rd;
    logic [1:0]       r_ob_cnt;
    logic [IDX_W-1:0] r_idx;

    logic signed [SUM_W-1:0] w_cxs, w_cys, w_xs, w_ys;
    logic signed [SUM_W-1:0] w_cpx, w_cmx, w_cpy, w_cmy;
    logic signed [SUM_W-1:0] w_rpx, w_rmx, w_rpy, w_rmy;
    logic signed [SUM_W-1:0] w_a, w_b, w_row, w_ws, w_hs;
    logic signed [SUM_W-1:0] w_ac, w_bc;
    logic [IDX_W-1:0]        w_last_idx;
    logic                    w_last, w_vis, w_issue, w_out_pop;
    t_out                    w_res;

    always_comb begin
        w_cxs = SUM_W'(i_job.cx);
        w_cys = SUM_W'(i_job.cy);
        w_xs  = signed'(SUM_W'(i_job.x));
        w_ys  = signed'(SUM_W'(i_job.y));
        w_cpx = w_cxs + w_xs;
        w_cmx = w_cxs - w_xs;
        w_cpy = w_cxs + w_ys;
        w_cmy = w_cxs - w_ys;
        w_rpx = w_cys + w_xs;
        w_rmx = w_cys - w_xs;
        w_rpy = w_cys + w_ys;
        w_rmy = w_cys - w_ys;
        w_a   = w_cpx;
        w_row = w_rpy;
        case (i_job.kind)
            K_START_OUT: w_last_idx = IDX_W'(3);
            K_ADV_FILL:  w_last_idx = IDX_W'(3);
            K_ADV_OUT:   w_last_idx = IDX_W'(7);
            default:     w_last_idx = '0;
        endcase
        case (i_job.kind)
            K_ADV_OUT: begin
                case (r_idx)
                    3'd0:    begin w_a = w_cpx; w_row = w_rpy; end
                    3'd1:    begin w_a = w_cmx; w_row = w_rpy; end
                    3'd2:    begin w_a = w_cpx; w_row = w_rmy; end
                    3'd3:    begin w_a = w_cmx; w_row = w_rmy; end
                    3'd4:    begin w_a = w_cpy; w_row = w_rpx; end
                    3'd5:    begin w_a = w_cmy; w_row = w_rpx; end
                    3'd6:    begin w_a = w_cpy; w_row = w_rmx; end
                    default: begin w_a = w_cmy; w_row = w_rmx; end
                endcase
                w_b = w_a;
            end
            K_START_OUT: begin
                case (r_idx)
                    3'd0:    begin w_a = w_cpx; w_row = w_rpy; end
                    3'd1:    begin w_a = w_cpx; w_row = w_rmy; end
                    3'd2:    begin w_a = w_cpy; w_row = w_rpx; end
                    default: begin w_a = w_cmy; w_row = w_rpx; end
                endcase
                w_b = w_a;
            end
            K_ADV_FILL: begin
                case (r_idx)
                    3'd0:    begin w_a = w_cmx; w_b = w_cpx; w_row = w_rpy; end
                    3'd1:    begin w_a = w_cmx; w_b = w_cpx; w_row = w_rmy; end
                    3'd2:    begin w_a = w_cmy; w_b = w_cpy; w_row = w_rpx; end
                    default: begin w_a = w_cmy; w_b = w_cpy; w_row = w_rmx; end
                endcase
            end
            default: begin
                w_a   = w_cmy;
                w_b   = w_cpy;
                w_row = w_rpx;
            end
        endcase

        w_ws  = signed'(SUM_W'(i_width));
        w_hs  = signed'(SUM_W'(i_height));
        w_vis = !(w_row < 0 || w_row >= w_hs || w_b < 0 || w_a >= w_ws);
        w_ac  = (w_a < 0) ? '0 : w_a;
        w_bc  = (w_b >= w_ws) ? (w_ws - SUM_W'(1)) : w_b;
        w_last = r_idx == w_last_idx;

        w_res            = '0;
        w_res.visible    = w_vis;
        w_res.last       = w_last;
        w_res.done_res   = i_job.done;
        if (w_vis) begin
            w_res.span_start = w_ac[PIX_W-1:0];
            w_res.span_end   = w_bc[PIX_W-1:0];
            w_res.row        = w_row[PIX_W-1:0];
        end
    end

    assign o_empty   = r_ob_cnt == '0;
    assign o_result  = r_ob[r_ob_rd];
    assign w_out_pop = i_pop && !o_empty;
    assign w_issue   = i_job_valid && (r_ob_cnt != 2'(OB_DEPTH) || w_out_pop);
    assign o_job_pop = w_issue && w_last;

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_ob[r_ob_wr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wr  <= 1'b0;
            r_ob_rd  <= 1'b0;
            r_ob_cnt <= '0;
            r_idx    <= '0;
        end else begin
            if (w_issue) begin
                r_ob_wr <= !r_ob_wr;
                r_idx   <= w_last ? '0 : r_idx + 1'b1;
            end
            if (w_out_pop) begin
                r_ob_rd <= !r_ob_rd;
            end
            r_ob_cnt <= r_ob_cnt + 2'(w_issue) - 2'(w_out_pop);
        end
    end

`ifndef SYNTHESIS
    a_ob_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_cnt <= 2'(OB_DEPTH))
        else $error("result buffer count out of range");
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_job_valid |-> r_idx == '0)
        else $error("emit index nonzero with no job");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> r_idx <= w_last_idx)
        else $error("emit index past end of job");
    a_idx_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_last) |=> r_idx == '0)
        else $error("emit index not cleared after last result");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/midpoint_circle_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_core
// Midpoint circle rasterizer: outline pixels or filled spans, clipped to a
// programmable display size.
// ----------------------------------------------------------------------------
// channel   dir  handshake               beat
// input     in   push / full             t_in: func, center, radius, fill
// result    out  empty / pop             t_out: span, row, visible, last, done
// config    in   i_cfg_valid/o_cfg_ready index 0 width, 1 height
//
// One result per cycle from the emit stage while its result buffer has room:
// an advance yields 8 (outline) or 4 (filled), a start 4 or 1; emit sets the rate.
// Decode steps on every accepted item; a 4-deep job queue decouples it from emit.
// Items that give no result are still accepted and decoded.
// Reset is synchronous; display size resets to 128 x 64.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_rasterizer_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire mcr_pkg::t_in                i_item,
    output logic                             empty,
    input  wire logic                        pop,
    output mcr_pkg::t_out                    o_result,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [1:0]                  i_cfg_index,
    input  wire logic [mcr_pkg::SIZE_W-1:0]  i_cfg_data
);
    import mcr_pkg::*;

    logic [SIZE_W-1:0] r_disp_w, r_disp_h;
    logic [SIZE_W-1:0] w_eff_w, w_eff_h;
    logic              w_accept, w_job_push, w_jq_full, w_job_valid, w_job_pop;
    t_job              w_job_in, w_job_head;

    assign o_cfg_ready = 1'b1;
    assign full        = w_jq_full;
    assign w_accept    = push && !w_jq_full;
    assign w_eff_w     = (r_disp_w > SIZE_W'(MAX_DISP)) ? SIZE_W'(MAX_DISP) : r_disp_w;
    assign w_eff_h     = (r_disp_h > SIZE_W'(MAX_DISP)) ? SIZE_W'(MAX_DISP) : r_disp_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_w <= SIZE_W'(128);
            r_disp_h <= SIZE_W'(64);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_disp_w <= i_cfg_data;
                CFG_HEIGHT: r_disp_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_item),
        .o_job_valid (w_job_push),
        .o_job       (w_job_in)
    );

    mcr_job_queue u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .o_full  (w_jq_full),
        .o_valid (w_job_valid),
        .o_job   (w_job_head),
        .i_pop   (w_job_pop)
    );

    mcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job_head),
        .o_job_pop   (w_job_pop),
        .i_width     (w_eff_w),
        .i_height    (w_eff_h),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ===== bench/midpoint_circle_rasterizer_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_core_test
// Self-checking bench for the midpoint circle rasterizer. Start and advance
// commands are queued, driven with random gaps, and every output beat is
// compared against a local span predictor across several display sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_rasterizer_core_test;

    import mcr_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    t_in               item = '0;
    logic              empty;
    logic              pop = 1'b0;
    t_out              result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = CFG_WIDTH;
    logic [SIZE_W-1:0] cfg_data = '0;

    t_in  draw_cmds[$];
    t_out expected_spans[$];

    // predictor state
    logic [SIZE_W-1:0] disp_w = 11'd128;
    logic [SIZE_W-1:0] disp_h = 11'd64;
    longint            org_x, org_y, walk_col, walk_row, err_term, err_col, err_row;
    logic              fill_on = 1'b0;
    logic              tracing = 1'b0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic rx_hold = 1'b0;
    int fail_count = 0;
    int cmds_taken = 0;
    int starts_taken = 0;
    int spans_checked = 0;

    midpoint_circle_rasterizer_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_item      (item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 40) begin
            $display("[%0t] %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [PIX_W-1:0] got,
                               input logic [PIX_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("beat %0d %s: got %0d, expected %0d",
                                      spans_checked, name, got, want));
        end
    endtask

    function automatic longint to_coord(input logic signed [IN_W-1:0] v);
        longint c;
        c = longint'(v);
        return (c <<< (64 - COORD_BITS)) >>> (64 - COORD_BITS);
    endfunction

    function automatic t_out clip_span(input longint a, input longint b, input longint y);
        t_out   o;
        longint w, h, t;
        o = '0;
        w = (disp_w > MAX_DISP) ? MAX_DISP : disp_w;
        h = (disp_h > MAX_DISP) ? MAX_DISP : disp_h;
        if (a > b) begin
            t = a;
            a = b;
            b = t;
        end
        if (y < 0 || y >= h || b < 0 || a >= w) begin
            return o;
        end
        if (a < 0) a = 0;
        if (b >= w) b = w - 1;
        o.span_start = PIX_W'(a);
        o.span_end   = PIX_W'(b);
        o.row        = PIX_W'(y);
        o.visible    = 1'b1;
        return o;
    endfunction

    task automatic rasterize(input t_in it);
        t_out   batch[$];
        longint r, x, y;
        logic   done;
        done = 1'b0;
        if (it.func == FUNC_START) begin
            r = longint'(it.radius);
            org_x = to_coord(it.center_x);
            org_y = to_coord(it.center_y);
            fill_on = it.fill;
            tracing = 1'b0;
            if (r < 0) begin
                return;
            end
            if (r == 0) begin
                batch.push_back(clip_span(org_x, org_x, org_y));
                done = 1'b1;
            end else begin
                err_term = 1 - r;
                err_col  = 1;
                err_row  = -2 * r;
                walk_col = 0;
                walk_row = r;
                tracing  = 1'b1;
                if (fill_on) begin
                    batch.push_back(clip_span(org_x - r, org_x + r, org_y));
                end else begin
                    batch.push_back(clip_span(org_x, org_x, org_y + r));
                    batch.push_back(clip_span(org_x, org_x, org_y - r));
                    batch.push_back(clip_span(org_x + r, org_x + r, org_y));
                    batch.push_back(clip_span(org_x - r, org_x - r, org_y));
                end
            end
        end else begin
            if (!tracing) begin
                return;
            end
            if (err_term >= 0) begin
                walk_row--;
                err_row += 2;
                err_term += err_row;
            end
            walk_col++;
            err_col += 2;
            err_term += err_col;
            x = walk_col;
            y = walk_row;
            if (fill_on) begin
                batch.push_back(clip_span(org_x - x, org_x + x, org_y + y));
                batch.push_back(clip_span(org_x - x, org_x + x, org_y - y));
                batch.push_back(clip_span(org_x - y, org_x + y, org_y + x));
                batch.push_back(clip_span(org_x - y, org_x + y, org_y - x));
            end else begin
                batch.push_back(clip_span(org_x + x, org_x + x, org_y + y));
                batch.push_back(clip_span(org_x - x, org_x - x, org_y + y));
                batch.push_back(clip_span(org_x + x, org_x + x, org_y - y));
                batch.push_back(clip_span(org_x - x, org_x - x, org_y - y));
                batch.push_back(clip_span(org_x + y, org_x + y, org_y + x));
                batch.push_back(clip_span(org_x - y, org_x - y, org_y + x));
                batch.push_back(clip_span(org_x + y, org_x + y, org_y - x));
                batch.push_back(clip_span(org_x - y, org_x - y, org_y - x));
            end
            tracing = walk_col < walk_row;
            done = !tracing;
        end
        foreach (batch[k]) begin
            batch[k].done_res = done;
            batch[k].last     = (k == batch.size() - 1);
            expected_spans.push_back(batch[k]);
        end
    endtask

    // driver: commands and pops change on the falling edge
    always @(negedge clk) begin
        if (!rst_n) begin
            push <= 1'b0;
            pop  <= 1'b0;
        end else begin
            if (draw_cmds.size() != 0 &&
                ((push && full) || $urandom_range(99) >= tx_idle_pct)) begin
                push <= 1'b1;
                item <= draw_cmds[0];
            end else begin
                push <= 1'b0;
            end
            pop <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // monitor: both handshakes sampled on the rising edge
    always @(posedge clk) begin : monitor
        t_out want;
        if (rst_n) begin
            if (push && !full) begin
                void'(draw_cmds.pop_front());
                rasterize(item);
                cmds_taken++;
                if (item.func == FUNC_START) starts_taken++;
            end
            if (pop && !empty) begin
                if (expected_spans.size() == 0) begin
                    report_mismatch($sformatf("beat %0d arrived with nothing expected",
                                              spans_checked));
                end else begin
                    want = expected_spans.pop_front();
                    check_field("span_start", result.span_start, want.span_start);
                    check_field("span_end", result.span_end, want.span_end);
                    check_field("row", result.row, want.row);
                    check_field("visible", PIX_W'(result.visible), PIX_W'(want.visible));
                    check_field("last", PIX_W'(result.last), PIX_W'(want.last));
                    check_field("done_res", PIX_W'(result.done_res),
                                PIX_W'(want.done_res));
                end
                spans_checked++;
            end
        end
    end

    task automatic queue_item(input logic f, input int x, input int y, input int r,
                              input logic fl);
        t_in it;
        it.func     = f;
        it.center_x = 16'(x);
        it.center_y = 16'(y);
        it.radius   = 16'(r);
        it.fill     = fl;
        draw_cmds.push_back(it);
    endtask

    task automatic queue_advances(input int n);
        repeat (n) begin
            queue_item(FUNC_ADVANCE, $urandom, $urandom, $urandom, 1'($urandom));
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [SIZE_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_WIDTH) disp_w = val;
        else disp_h = val;
    endtask

    task automatic set_display(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_all();
        do @(posedge clk); while (draw_cmds.size() != 0 || expected_spans.size() != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic load_random(input int n);
        int made, pick, r, steps, span_x, span_y, ox, oy;
        @(posedge clk);
        made = 0;
        span_x = ((disp_w > MAX_DISP) ? MAX_DISP : disp_w) + 40;
        span_y = ((disp_h > MAX_DISP) ? MAX_DISP : disp_h) + 40;
        while (made < n) begin
            pick = $urandom_range(99);
            if ($urandom_range(9) == 0) begin
                ox = $urandom;
                oy = $urandom;
            end else begin
                ox = int'($urandom_range(span_x)) - 20;
                oy = int'($urandom_range(span_y)) - 20;
            end
            if (pick < 94) begin
                if (pick < 70) begin
                    r = $urandom_range(1, 24);
                    steps = r * 707 / 1000 + $urandom_range(1);
                end else if (pick < 80) begin
                    r = $urandom_range(25, 32767);
                    steps = $urandom_range(3);
                end else if (pick < 86) begin
                    r = 0 - int'($urandom_range(1, 32768));
                    steps = $urandom_range(1);
                end else if (pick < 89) begin
                    r = 0;
                    steps = $urandom_range(1);
                end else begin
                    r = -1;
                    steps = 0;
                end
                if (r == -1) begin
                    queue_advances(1);
                    made++;
                end else begin
                    queue_item(FUNC_START, ox, oy, r, 1'($urandom));
                    queue_advances(steps);
                    made += 1 + steps;
                end
            end else begin
                queue_item(1'($urandom), $urandom, $urandom, $urandom, 1'($urandom));
                made++;
            end
        end
    endtask

    // long receiver hold-off while commands keep coming
    initial begin
        wait (cmds_taken >= 45);
        @(negedge clk);
        rx_hold <= 1'b1;
        repeat (300) @(negedge clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 36;
        rx_idle_pct = 84;

        @(posedge clk);
        queue_item(FUNC_START, 5, 5, 0, 1'b0);
        queue_item(FUNC_START, 0, 0, 0, 1'b1);
        queue_item(FUNC_START, 10, 10, -1, 1'b0);
        queue_item(FUNC_ADVANCE, -1, -1, -1, 1'b1);
        queue_item(FUNC_START, 10, 10, 3, 1'b0);
        queue_advances(3);
        queue_item(FUNC_START, 0, 0, 2, 1'b1);
        queue_advances(2);
        queue_item(FUNC_START, -32768, 32767, 32767, 1'b0);
        queue_advances(1);
        queue_item(FUNC_START, 32767, -32768, 32767, 1'b1);
        queue_advances(1);
        queue_item(FUNC_START, 0, 0, -32768, 1'b1);
        queue_item(FUNC_START, 126, 62, 5, 1'b0);
        queue_advances(2);
        queue_item(FUNC_START, 127, 63, 1, 1'b1);
        queue_advances(1);
        drain_all();

        set_display(11'd1024, 11'd1024);
        load_random(60);
        drain_all();

        tx_idle_pct = 84;
        rx_idle_pct = 36;
        set_display(11'd1, 11'd2047);
        load_random(40);
        drain_all();

        set_display(11'd0, 11'd40);
        load_random(30);
        drain_all();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_display(11'd2047, 11'd1);
        load_random(25);
        drain_all();

        set_display(11'd200, 11'd150);
        load_random(25);
        drain_all();

        if (expected_spans.size() != 0) begin
            report_mismatch($sformatf("%0d beats never delivered", expected_spans.size()));
        end
        $display("Drew %0d commands (%0d circle starts) over six display sizes,",
                 cmds_taken, starts_taken);
        $display("checked %0d output beats field by field, %0d mismatches.",
                 spans_checked, fail_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
